FILE: rtl/hpta_pkg.sv
// ----------------------------------------------------------------------------
// Heading PID thrust allocator package
// Widths, register indexes, reset values, sequencer states and pulse width
// constants shared by the heading PID thrust allocator.
// ----------------------------------------------------------------------------
package hpta_pkg;

   // Field widths.
   localparam int ANGLE_W    = 32;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PWM_W      = 11;
   localparam int INTEG_W    = 48;

   // Shared multiplier: 17-bit signed by 49-bit signed, product kept at 64 bits.
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 49;
   localparam int PROD_W  = 64;

   // Shared divider: 56-bit magnitude by 16-bit divisor, four bits per cycle.
   localparam int DIV_N_W   = 56;
   localparam int DIV_D_W   = 16;
   localparam int DIV_STEPS = 4;
   localparam int DIV_ITERS = DIV_N_W / DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_ITERS);

   // Internal sums.
   localparam int ACC_W   = 59;
   localparam int DELTA_W = 50;
   localparam int FORCE_W = 51;

   // Saturation limits.
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   // Pulse width mapping: 1500 + force * 400 / 50, clamped to 1100..1900.
   localparam int PWM_CENTER = 1500;
   localparam int PWM_SPAN   = 400;
   localparam int PWM_MAX    = 1900;
   localparam int PWM_MIN    = 1100;
   localparam int FORCE_FULL = 50;
   localparam int FORCE_DIV  = 65536 * FORCE_FULL / PWM_SPAN;
   localparam int BOW_SHIFT  = $clog2(FORCE_DIV);
   localparam int SIDE_SHIFT = BOW_SHIFT + 1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_OFFSET   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOW_ARM       = 3'd5;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] RST_GAIN_PROP     = 16'd1024;
   localparam logic [CSR_DATA_W-1:0] RST_GAIN_INTEG    = 16'd0;
   localparam logic [CSR_DATA_W-1:0] RST_GAIN_DERIV    = 16'd256;
   localparam logic [CSR_DATA_W-1:0] RST_SAMPLE_PERIOD = 16'd6554;
   localparam logic [CSR_DATA_W-1:0] RST_BEAM_OFFSET   = 16'd128;
   localparam logic [CSR_DATA_W-1:0] RST_BOW_ARM       = 16'd256;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_INC,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_DIV_D_LOAD,
      ST_DIV_D,
      ST_SUM_D,
      ST_YAW,
      ST_DIV_A_LOAD,
      ST_DIV_A,
      ST_DELTA,
      ST_PWM
   } seq_state_type;

endpackage

FILE: rtl/heading_pid_thrust_allocator.sv
// ----------------------------------------------------------------------------
// Heading PID thrust allocator
// Heading PID step followed by a three-thruster force allocation and pulse
// width mapping, built around one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Content
//   req_*     in         req_valid/req_ready  target, measured, surge, sway
//   rsp_*     out        rsp_valid/rsp_ready  yaw moment, left/right/bow pwm
//   csr_*     in         csr_wr_en            register index and data
//
// An item passes through the multiplier steps and two passes through the
// shared radix-16 divider before it reaches the result register; a new item
// is accepted only once the sequencer has finished the last one.
// req_ready is high only while the sequencer is idle. A waiting result blocks
// the next one at its last step only; while it waits there, no item is taken.
// Synchronous reset restores the register defaults and clears the integral,
// the previous error and the result valid flag.
//
module heading_pid_thrust_allocator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [hpta_pkg::ANGLE_W-1:0]    req_target_angle,
   input  logic signed [hpta_pkg::ANGLE_W-1:0]    req_measured_angle,
   input  logic signed [hpta_pkg::ANGLE_W-1:0]    req_surge_force,
   input  logic signed [hpta_pkg::ANGLE_W-1:0]    req_sway_force,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [hpta_pkg::ANGLE_W-1:0]    rsp_yaw_moment,
   output logic        [hpta_pkg::PWM_W-1:0]      rsp_pwm_left,
   output logic        [hpta_pkg::PWM_W-1:0]      rsp_pwm_right,
   output logic        [hpta_pkg::PWM_W-1:0]      rsp_pwm_bow,
   input  logic                                   csr_wr_en,
   input  logic        [hpta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [hpta_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hpta_pkg::*;

   localparam logic signed [FORCE_W-1:0] Q_HI = FORCE_W'(PWM_SPAN);
   localparam logic signed [FORCE_W-1:0] Q_LO = -FORCE_W'(PWM_SPAN);
   localparam logic signed [FORCE_W-1:0] SIDE_BIAS = FORCE_W'((1 << SIDE_SHIFT) - 1);
   localparam logic signed [FORCE_W-1:0] BOW_BIAS  = FORCE_W'((1 << BOW_SHIFT) - 1);
   localparam logic signed [FORCE_W-1:0] NO_BIAS   = '0;

   // Map a truncated force quotient to a clamped pulse width.
   function automatic logic [PWM_W-1:0] pwm_clamp(input logic signed [FORCE_W-1:0] q);
      logic [PWM_W-1:0] pwm;
      if (q > Q_HI) begin
         pwm = PWM_W'(PWM_MAX);
      end else if (q < Q_LO) begin
         pwm = PWM_W'(PWM_MIN);
      end else begin
         pwm = PWM_W'(PWM_CENTER) + q[PWM_W-1:0];
      end
      return pwm;
   endfunction

   // Configuration registers.
   logic signed [GAIN_W-1:0]     kp_ff, ki_ff, kd_ff;
   logic        [CSR_DATA_W-1:0] dt_ff, beam_ff, arm_ff;

   // Sequencer and datapath registers.
   seq_state_type               state_ff, state_in;
   logic signed [ANGLE_W-1:0]   err_ff, err_in;
   logic signed [ANGLE_W-1:0]   last_err_ff, last_err_in;
   logic signed [INTEG_W-1:0]   integ_ff, integ_in;
   logic signed [ANGLE_W-1:0]   surge_ff, surge_in;
   logic signed [ANGLE_W-1:0]   sway_ff, sway_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ANGLE_W-1:0]   yaw_ff, yaw_in;
   logic signed [DELTA_W-1:0]   delta_ff, delta_in;
   logic signed [PROD_W-1:0]    prod_ff;

   // Divider registers.
   logic [DIV_D_W-1:0]   div_rem_ff, div_rem_in;
   logic [DIV_N_W-1:0]   div_quo_ff, div_quo_in;
   logic [DIV_D_W-1:0]   div_den_ff, div_den_in;
   logic                 div_neg_ff, div_neg_in;
   logic                 div_zero_ff, div_zero_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_yaw_ff, rsp_yaw_in;
   logic [PWM_W-1:0]          rsp_left_ff, rsp_left_in;
   logic [PWM_W-1:0]          rsp_right_ff, rsp_right_in;
   logic [PWM_W-1:0]          rsp_bow_ff, rsp_bow_in;

   // Multiplier controls.
   logic                          mul_en;
   logic signed [MUL_A_W-1:0]     mul_a;
   logic signed [MUL_B_W-1:0]     mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;

   // Combinational helpers.
   logic                        req_fire;
   logic                        rsp_load;
   logic signed [ANGLE_W:0]     err_raw;
   logic signed [ANGLE_W-1:0]   err_sat;
   logic signed [ANGLE_W:0]     err_diff;
   logic signed [ANGLE_W-1:0]   integ_inc;
   logic signed [INTEG_W:0]     integ_sum;
   logic signed [INTEG_W-1:0]   integ_sat;
   logic signed [39:0]          pterm;
   logic signed [PROD_W-9:0]    iterm;
   logic signed [MUL_B_W-1:0]   dprod;
   logic signed [MUL_B_W-1:0]   dmag;
   logic signed [DELTA_W-1:0]   alloc_num;
   logic signed [DELTA_W-1:0]   alloc_mag;
   logic signed [DIV_N_W:0]     div_q_pos;
   logic signed [DIV_N_W:0]     div_q;
   logic                        acc_fits;
   logic signed [ANGLE_W-1:0]   yaw_sat;
   logic signed [FORCE_W-1:0]   left_sum, right_sum, bow_sum;
   logic signed [FORCE_W-1:0]   left_q, right_q, bow_q;
   logic [DIV_D_W-1:0]          step_rem;
   logic [DIV_N_W-1:0]          step_quo;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_PWM) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_yaw_moment = rsp_yaw_ff;
   assign rsp_pwm_left   = rsp_left_ff;
   assign rsp_pwm_right  = rsp_right_ff;
   assign rsp_pwm_bow    = rsp_bow_ff;

   // Heading error, saturated to 32 bits.
   assign err_raw = (ANGLE_W+1)'(req_target_angle) - (ANGLE_W+1)'(req_measured_angle);
   always_comb begin
      if (err_raw[ANGLE_W] != err_raw[ANGLE_W-1]) begin
         err_sat = err_raw[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
      end else begin
         err_sat = err_raw[ANGLE_W-1:0];
      end
   end

   // Change of error since the previous item.
   assign err_diff = (ANGLE_W+1)'(err_ff) - (ANGLE_W+1)'(last_err_ff);

   // Integral update from error times period, saturated to 48 bits.
   assign integ_inc = prod_ff[47:16];
   assign integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(integ_inc);
   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
   end

   // Proportional and integral terms, floor of the product over 256.
   assign pterm = prod_ff[47:8];
   assign iterm = prod_ff[PROD_W-1:8];

   // Derivative dividend magnitude: gain times error change, times 256.
   assign dprod = prod_ff[MUL_B_W-1:0];
   assign dmag  = dprod[MUL_B_W-1] ? -dprod : dprod;

   // Allocation dividend: yaw times 256 minus bow arm times sway.
   assign alloc_num = {{(DELTA_W-ANGLE_W-8){yaw_ff[ANGLE_W-1]}}, yaw_ff, 8'h00}
                      - DELTA_W'(dprod);
   assign alloc_mag = alloc_num[DELTA_W-1] ? -alloc_num : alloc_num;

   // Signed quotient, truncated toward zero; a zero divisor gives zero.
   assign div_q_pos = {1'b0, div_quo_ff};
   always_comb begin
      if (div_zero_ff) begin
         div_q = '0;
      end else if (div_neg_ff) begin
         div_q = -div_q_pos;
      end else begin
         div_q = div_q_pos;
      end
   end

   // Yaw moment saturation.
   assign acc_fits = (&acc_ff[ACC_W-1:ANGLE_W-1]) || !(|acc_ff[ACC_W-1:ANGLE_W-1]);
   assign yaw_sat  = acc_fits ? acc_ff[ANGLE_W-1:0]
                              : (acc_ff[ACC_W-1] ? ANGLE_MIN : ANGLE_MAX);

   // Thruster forces and their truncated pulse quotients.
   assign left_sum  = FORCE_W'(surge_ff) + FORCE_W'(delta_ff);
   assign right_sum = FORCE_W'(surge_ff) - FORCE_W'(delta_ff);
   assign bow_sum   = FORCE_W'(sway_ff);
   assign left_q  = (left_sum  + (left_sum[FORCE_W-1]  ? SIDE_BIAS : NO_BIAS)) >>> SIDE_SHIFT;
   assign right_q = (right_sum + (right_sum[FORCE_W-1] ? SIDE_BIAS : NO_BIAS)) >>> SIDE_SHIFT;
   assign bow_q   = (bow_sum   + (bow_sum[FORCE_W-1]   ? BOW_BIAS  : NO_BIAS)) >>> BOW_SHIFT;

   // Four restoring division steps per cycle.
   always_comb begin
      logic [DIV_D_W:0] trial;
      step_rem = div_rem_ff;
      step_quo = div_quo_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {step_rem, step_quo[DIV_N_W-1]};
         if (trial >= {1'b0, div_den_ff}) begin
            trial = trial - {1'b0, div_den_ff};
            step_quo = {step_quo[DIV_N_W-2:0], 1'b1};
         end else begin
            step_quo = {step_quo[DIV_N_W-2:0], 1'b0};
         end
         step_rem = trial[DIV_D_W-1:0];
      end
   end

   // Shared multiplier.
   assign mul_full = mul_a * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_fire) state_in = ST_MUL_INC;
         ST_MUL_INC:    state_in = ST_MUL_P;
         ST_MUL_P:      state_in = ST_MUL_I;
         ST_MUL_I:      state_in = ST_MUL_D;
         ST_MUL_D:      state_in = ST_DIV_D_LOAD;
         ST_DIV_D_LOAD: state_in = ST_DIV_D;
         ST_DIV_D:      if (div_cnt_ff == '0) state_in = ST_SUM_D;
         ST_SUM_D:      state_in = ST_YAW;
         ST_YAW:        state_in = ST_DIV_A_LOAD;
         ST_DIV_A_LOAD: state_in = ST_DIV_A;
         ST_DIV_A:      if (div_cnt_ff == '0) state_in = ST_DELTA;
         ST_DELTA:      state_in = ST_PWM;
         ST_PWM:        if (rsp_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath controls per state.
   always_comb begin
      err_in      = err_ff;
      last_err_in = last_err_ff;
      integ_in    = integ_ff;
      surge_in    = surge_ff;
      sway_in     = sway_ff;
      acc_in      = acc_ff;
      yaw_in      = yaw_ff;
      delta_in    = delta_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_den_in  = div_den_ff;
      div_neg_in  = div_neg_ff;
      div_zero_in = div_zero_ff;
      div_cnt_in  = div_cnt_ff;
      mul_en      = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_bow_in   = rsp_bow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               err_in   = err_sat;
               surge_in = req_surge_force;
               sway_in  = req_sway_force;
            end
         end
         ST_MUL_INC: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, dt_ff};
            mul_b  = MUL_B_W'(err_ff);
         end
         ST_MUL_P: begin
            integ_in = integ_sat;
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(kp_ff);
            mul_b    = MUL_B_W'(err_ff);
         end
         ST_MUL_I: begin
            acc_in = ACC_W'(pterm);
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(ki_ff);
            mul_b  = MUL_B_W'(integ_ff);
         end
         ST_MUL_D: begin
            acc_in      = acc_ff + ACC_W'(iterm);
            last_err_in = err_ff;
            mul_en      = 1'b1;
            mul_a       = MUL_A_W'(kd_ff);
            mul_b       = MUL_B_W'(err_diff);
         end
         ST_DIV_D_LOAD: begin
            // Derivative division by the period; the bow moment product
            // is started here and kept in the product register.
            div_quo_in  = {dmag[DIV_N_W-9:0], 8'h00};
            div_rem_in  = '0;
            div_den_in  = dt_ff;
            div_neg_in  = dprod[MUL_B_W-1];
            div_zero_in = (dt_ff == '0);
            div_cnt_in  = DIV_CNT_W'(DIV_ITERS - 1);
            mul_en      = 1'b1;
            mul_a       = {1'b0, arm_ff};
            mul_b       = MUL_B_W'(sway_ff);
         end
         ST_DIV_D, ST_DIV_A: begin
            div_rem_in = step_rem;
            div_quo_in = step_quo;
            div_cnt_in = div_cnt_ff - 1'b1;
         end
         ST_SUM_D: begin
            acc_in = acc_ff + ACC_W'(div_q);
         end
         ST_YAW: begin
            yaw_in = yaw_sat;
         end
         ST_DIV_A_LOAD: begin
            // Side thruster difference: divide by the beam offset.
            div_quo_in  = DIV_N_W'(alloc_mag);
            div_rem_in  = '0;
            div_den_in  = beam_ff;
            div_neg_in  = alloc_num[DELTA_W-1];
            div_zero_in = (beam_ff == '0);
            div_cnt_in  = DIV_CNT_W'(DIV_ITERS - 1);
         end
         ST_DELTA: begin
            delta_in = div_q[DELTA_W-1:0];
         end
         ST_PWM: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_yaw_in   = yaw_ff;
               rsp_left_in  = pwm_clamp(left_q);
               rsp_right_in = pwm_clamp(right_q);
               rsp_bow_in   = pwm_clamp(bow_q);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         kp_ff        <= RST_GAIN_PROP;
         ki_ff        <= RST_GAIN_INTEG;
         kd_ff        <= RST_GAIN_DERIV;
         dt_ff        <= RST_SAMPLE_PERIOD;
         beam_ff      <= RST_BEAM_OFFSET;
         arm_ff       <= RST_BOW_ARM;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_err_ff  <= last_err_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GAIN_PROP:     kp_ff   <= csr_wdata;
               CSR_GAIN_INTEG:    ki_ff   <= csr_wdata;
               CSR_GAIN_DERIV:    kd_ff   <= csr_wdata;
               CSR_SAMPLE_PERIOD: dt_ff   <= csr_wdata;
               CSR_BEAM_OFFSET:   beam_ff <= csr_wdata;
               CSR_BOW_ARM:       arm_ff  <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      surge_ff     <= surge_in;
      sway_ff      <= sway_in;
      acc_ff       <= acc_in;
      yaw_ff       <= yaw_in;
      delta_ff     <= delta_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_neg_ff   <= div_neg_in;
      div_zero_ff  <= div_zero_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_bow_ff   <= rsp_bow_in;
      if (mul_en) begin
         prod_ff <= mul_full[PROD_W-1:0];
      end
   end

endmodule
